// ----- rtl/core/sspq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspq_pkg
// shared types and constants of the stable sorted priority queue
// ----------------------------------------------------------------------------
package sspq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int VALUE_BITS    = 32;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

   // request kind codes
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

   // one slot of the sorted row
   typedef struct packed {
      logic                     valid;
      logic [PRIORITY_BITS-1:0] prio;
      logic [VALUE_BITS-1:0]    value;
   } slot_type;

   // broadcast command seen by every cell
   typedef struct packed {
      cell_op_type              op;
      logic [PRIORITY_BITS-1:0] prio;
      logic [VALUE_BITS-1:0]    value;
   } cell_cmd_type;

endpackage

// ----- rtl/core/stable_sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// bounded priority queue held as a sorted row of compare-and-shift cells
// ----------------------------------------------------------------------------
// result: the result word is registered and appears in the cycle after the request word is taken
// throughput: one request word per cycle while no held result word stalls req_ready, set by the
//   compare-and-shift that every cell performs in parallel
// reset: clears all slot valid bits, the entry count and the result valid;
//   slot payloads are not cleared and are only read while valid
module stable_sorted_priority_queue_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [sspq_pkg::PRIORITY_BITS-1:0]  req_priority_req,
   input  logic signed [sspq_pkg::VALUE_BITS-1:0] req_value,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [sspq_pkg::VALUE_BITS-1:0] rsp_removed_value,
   output logic [sspq_pkg::PRIORITY_BITS-1:0]  rsp_removed_priority,
   output logic                                rsp_head_valid,
   output logic signed [sspq_pkg::VALUE_BITS-1:0] rsp_head_value,
   output logic [sspq_pkg::COUNT_BITS-1:0]     rsp_occupancy
);
   import sspq_pkg::*;

   // row of cells, slot 0 is the head
   slot_type                 slots [CAPACITY];
   logic [CAPACITY-1:0]      keeps;
   cell_cmd_type             cmd;

   logic                     in_fire;
   logic                     is_full;
   logic                     is_empty;

   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;

   // result register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               status_ff;
   status_type               status_in;
   logic [VALUE_BITS-1:0]    rem_value_ff;
   logic [VALUE_BITS-1:0]    rem_value_in;
   logic [PRIORITY_BITS-1:0] rem_prio_ff;
   logic [PRIORITY_BITS-1:0] rem_prio_in;
   logic [VALUE_BITS-1:0]    head_value_ff;
   logic [VALUE_BITS-1:0]    head_value_in;
   slot_type                 head_next;

   // a new word may enter while the held result is being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign in_fire   = req_valid && req_ready;
   assign is_full   = (count_ff == COUNT_BITS'(CAPACITY));
   assign is_empty  = (count_ff == '0);

   // decode the request into one command for the whole row
   always_comb begin
      cmd.op    = OP_HOLD;
      cmd.prio  = req_priority_req;
      cmd.value = req_value;
      status_in = STATUS_DONE;
      count_in  = count_ff;
      if (in_fire) begin
         case (req_kind)
            KIND_INSERT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd.op   = OP_INSERT;
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end
            KIND_REMOVE: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  cmd.op   = OP_REMOVE;
                  count_in = count_ff - COUNT_BITS'(1);
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   // chain of cells: each sees its left and right neighbour
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slot_type left_slot;
      slot_type right_slot;
      logic     left_keep;

      if (i == 0) begin : g_first
         assign left_slot = '0;
         assign left_keep = 1'b1;
      end else begin : g_inner
         assign left_slot = slots[i-1];
         assign left_keep = keeps[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_body
         assign right_slot = slots[i+1];
      end

      sspq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_keep  (left_keep),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .keep       (keeps[i])
      );
   end

   // head entry after this step, mirrors what cell 0 will load
   always_comb begin
      head_next = slots[0];
      case (cmd.op)
         OP_INSERT: begin
            if (!keeps[0]) begin
               head_next = '{valid: 1'b1, prio: cmd.prio, value: cmd.value};
            end
         end
         OP_REMOVE: begin
            head_next = slots[1];
         end
         default: begin
            head_next = slots[0];
         end
      endcase
   end

   // popped entry, zero unless a remove really took place
   assign rem_value_in  = (cmd.op == OP_REMOVE) ? slots[0].value : '0;
   assign rem_prio_in   = (cmd.op == OP_REMOVE) ? slots[0].prio  : '0;
   assign head_value_in = (count_in != '0) ? head_next.value : '0;
   assign rsp_valid_in  = in_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload loads only on an accepted word
   always_ff @(posedge clock) begin
      if (in_fire) begin
         status_ff     <= status_in;
         rem_value_ff  <= rem_value_in;
         rem_prio_ff   <= rem_prio_in;
         head_value_ff <= head_value_in;
      end
   end

   // occupancy and head valid follow the live count, which only moves on accept
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_value    = rem_value_ff;
   assign rsp_removed_priority = rem_prio_ff;
   assign rsp_head_valid       = (count_ff != '0);
   assign rsp_head_value       = head_value_ff;
   assign rsp_occupancy        = count_ff;

endmodule

// ----- rtl/core/sspq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspq_cell
// one slot of the sorted row: compare, keep, load or shift from a neighbour
// ----------------------------------------------------------------------------
module sspq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  sspq_pkg::cell_cmd_type cmd,
   input  logic                 left_keep,
   input  sspq_pkg::slot_type   left_slot,
   input  sspq_pkg::slot_type   right_slot,
   output sspq_pkg::slot_type   slot,
   output logic                 keep
);
   import sspq_pkg::*;

   logic                     valid_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic [VALUE_BITS-1:0]    value_ff;
   slot_type                 slot_in;

   assign slot = '{valid: valid_ff, prio: prio_ff, value: value_ff};

   // entry stays put when it is at or ahead of the new priority
   assign keep = valid_ff && (prio_ff <= cmd.prio);

   always_comb begin
      slot_in = slot;
      case (cmd.op)
         OP_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  slot_in = '{valid: 1'b1, prio: cmd.prio, value: cmd.value};
               end else begin
                  slot_in = left_slot;
               end
            end
         end
         OP_REMOVE: begin
            slot_in = right_slot;
         end
         default: begin
            slot_in = slot;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= slot_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff  <= slot_in.prio;
      value_ff <= slot_in.value;
   end

endmodule

// ----- rtl/core/sspq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspq_checker
// port-level checks of the sorted priority queue, bound to the top level
// ----------------------------------------------------------------------------
module sspq_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [1:0]                             rsp_status,
   input logic signed [sspq_pkg::VALUE_BITS-1:0] rsp_removed_value,
   input logic                                   rsp_head_valid,
   input logic [sspq_pkg::COUNT_BITS-1:0]        rsp_occupancy
);
   import sspq_pkg::*;

   // a held result word must not vanish before it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= COUNT_BITS'(CAPACITY))
      else $error("occupancy above capacity");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_valid == (rsp_occupancy != '0)))
      else $error("head valid disagrees with occupancy");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_occupancy == COUNT_BITS'(CAPACITY))
      else $error("insert dropped while not full");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
         rsp_occupancy == '0 && rsp_removed_value == '0)
      else $error("empty remove reported with entries or data");

endmodule

bind stable_sorted_priority_queue_core sspq_checker u_sspq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_head_valid    (rsp_head_valid),
   .rsp_occupancy     (rsp_occupancy)
);

// ----- bench/sspq_order_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspq_order_checker
// follows every request word into its own sorted copy of the queue, works out
// the result word it must cause and compares it with the word that comes out
// ----------------------------------------------------------------------------
module sspq_order_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_ready,
   input  logic                                      req_kind,
   input  logic [sspq_pkg::PRIORITY_BITS-1:0]        req_priority_req,
   input  logic signed [sspq_pkg::VALUE_BITS-1:0]    req_value,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   input  logic [1:0]                                rsp_status,
   input  logic signed [sspq_pkg::VALUE_BITS-1:0]    rsp_removed_value,
   input  logic [sspq_pkg::PRIORITY_BITS-1:0]        rsp_removed_priority,
   input  logic                                      rsp_head_valid,
   input  logic signed [sspq_pkg::VALUE_BITS-1:0]    rsp_head_value,
   input  logic [sspq_pkg::COUNT_BITS-1:0]           rsp_occupancy,
   output int                                        mismatch_count,
   output int                                        pending_count
);
   import sspq_pkg::*;

   typedef struct {
      status_type                  status;
      logic signed [VALUE_BITS-1:0] removed_value;
      logic [PRIORITY_BITS-1:0]    removed_priority;
      logic                        head_valid;
      logic signed [VALUE_BITS-1:0] head_value;
      logic [COUNT_BITS-1:0]       occupancy;
   } outcome_type;

   logic [PRIORITY_BITS-1:0]     slot_prio  [CAPACITY];
   logic signed [VALUE_BITS-1:0] slot_value [CAPACITY];
   int unsigned                  fill_level = 0;
   outcome_type                  outcome_q [$];
   int                           errors_seen = 0;

   // one step of the sorted row: insert behind equal priorities, pop from the front
   function automatic outcome_type apply_word(input logic kind,
                                              input logic [PRIORITY_BITS-1:0] prio,
                                              input logic signed [VALUE_BITS-1:0] value);
      outcome_type o;
      int unsigned pos;
      o.status           = STATUS_DONE;
      o.removed_value    = '0;
      o.removed_priority = '0;
      if (kind == KIND_INSERT) begin
         if (fill_level >= CAPACITY) begin
            o.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < fill_level && slot_prio[pos] <= prio) pos++;
            for (int unsigned i = fill_level; i > pos; i--) begin
               slot_prio[i]  = slot_prio[i-1];
               slot_value[i] = slot_value[i-1];
            end
            slot_prio[pos]  = prio;
            slot_value[pos] = value;
            fill_level++;
         end
      end else begin
         if (fill_level == 0) begin
            o.status = STATUS_EMPTY;
         end else begin
            o.removed_value    = slot_value[0];
            o.removed_priority = slot_prio[0];
            for (int unsigned i = 0; i + 1 < fill_level; i++) begin
               slot_prio[i]  = slot_prio[i+1];
               slot_value[i] = slot_value[i+1];
            end
            fill_level--;
         end
      end
      o.head_valid = (fill_level != 0);
      o.head_value = o.head_valid ? slot_value[0] : '0;
      o.occupancy  = COUNT_BITS'(fill_level);
      return o;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %h actual %h", $time, field, want, got);
         errors_seen++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         fill_level = 0;
         outcome_q.delete();
      end else begin
         if (req_valid && req_ready)
            outcome_q.push_back(apply_word(req_kind, req_priority_req, req_value));
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t ns: result word expected none actual status %h occupancy %0d",
                        $time, rsp_status, rsp_occupancy);
               errors_seen++;
            end else begin
               want = outcome_q.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("removed_value", want.removed_value, rsp_removed_value);
               check_field("removed_priority", want.removed_priority, rsp_removed_priority);
               check_field("head_valid", want.head_valid, rsp_head_valid);
               check_field("head_value", want.head_value, rsp_head_value);
               check_field("occupancy", want.occupancy, rsp_occupancy);
            end
         end
      end
      mismatch_count <= errors_seen;
      pending_count  <= outcome_q.size();
   end

endmodule

// ----- bench/stable_sorted_priority_queue_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core_tb
// drives insert and remove words into the sorted queue with random gaps and
// result stalls; the order checker beside the block judges every result word
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_core_tb;
   import sspq_pkg::*;

   localparam int RANDOM_WORDS = 1350;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_kind = KIND_INSERT;
   logic [PRIORITY_BITS-1:0]     req_priority_req = '0;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_status;
   logic signed [VALUE_BITS-1:0] rsp_removed_value;
   logic [PRIORITY_BITS-1:0]     rsp_removed_priority;
   logic                         rsp_head_valid;
   logic signed [VALUE_BITS-1:0] rsp_head_value;
   logic [COUNT_BITS-1:0]        rsp_occupancy;

   int          mismatch_count;
   int          pending_count;
   // brisk: no gaps on either side, so words go back to back
   logic        brisk = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned stall_draw;

   always #4 clock = ~clock;

   stable_sorted_priority_queue_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_priority_req     (req_priority_req),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_removed_value    (rsp_removed_value),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_head_valid       (rsp_head_valid),
      .rsp_head_value       (rsp_head_value),
      .rsp_occupancy        (rsp_occupancy)
   );

   sspq_order_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_priority_req     (req_priority_req),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_removed_value    (rsp_removed_value),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_head_valid       (rsp_head_valid),
      .rsp_head_value       (rsp_head_value),
      .rsp_occupancy        (rsp_occupancy),
      .mismatch_count       (mismatch_count),
      .pending_count        (pending_count)
   );

   // result side: after each taken word, draw a stall and hold ready low until it counts down; brisk draws none
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall_draw = brisk ? 0 : $urandom_range(0, 4);
         rsp_hold  <= stall_draw;
         rsp_ready <= (stall_draw == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // priorities lean on the ends of the range and on a few small numbers, so
   // that ties are frequent and the arrival order of equals gets exercised
   function automatic logic [PRIORITY_BITS-1:0] pick_priority();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return PRIORITY_BITS'($urandom_range(0, 3));
         default: return PRIORITY_BITS'($urandom);
      endcase
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // offer one request word, entered and left at a rising edge; valid is only
   // dropped when a gap is drawn, so back-to-back words keep it high
   task automatic send_word(input logic kind, input logic [PRIORITY_BITS-1:0] prio,
                            input logic signed [VALUE_BITS-1:0] value);
      int unsigned gap;
      gap = brisk ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_priority_req <= prio;
      req_value        <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending until every result word owed has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      int          sent;
      int unsigned seg_len;
      int unsigned insert_pct;
      logic        drained_mid;
      sent        = 0;
      drained_mid = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: remove on an empty queue
      send_word(KIND_REMOVE, '1, '1);
      // extremes of priority and value, new head, ties behind existing equals
      send_word(KIND_INSERT, 8'd255, 32'sh7fff_ffff);
      send_word(KIND_INSERT, 8'd0, 32'sh8000_0000);
      send_word(KIND_INSERT, 8'd128, 32'sd1);
      send_word(KIND_INSERT, 8'd128, 32'sd2);
      send_word(KIND_INSERT, 8'd0, -32'sd1);
      // fill to capacity, then one more insert must be dropped as full
      repeat (11) send_word(KIND_INSERT, pick_priority(), pick_value());
      send_word(KIND_INSERT, 8'd0, 32'sh5a5a_a5a5);
      // pop a few from the front in order
      repeat (4) send_word(KIND_REMOVE, pick_priority(), pick_value());
      wait_for_drain();

      // random: segments that lean towards filling, draining or balance, some
      // of them with no gaps on either side
      while (sent < RANDOM_WORDS) begin
         seg_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0:       insert_pct = 80;
            1:       insert_pct = 25;
            default: insert_pct = 50;
         endcase
         brisk = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            if ($urandom_range(0, 99) < insert_pct)
               send_word(KIND_INSERT, pick_priority(), pick_value());
            else
               send_word(KIND_REMOVE, pick_priority(), pick_value());
            sent++;
         end
         // one pause mid-run until the queue of owed result words is empty
         if (!drained_mid && sent >= RANDOM_WORDS / 2) begin
            wait_for_drain();
            drained_mid = 1'b1;
         end
      end
      brisk = 1'b0;

      wait_for_drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // timeout set far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
